/* sv/rscrm_pkg.sv */
// ----------------------------------------------------------------------------
// rscrm_pkg: shared types and constants of the column-to-row mapper
// Holds the register index codes, the sequencer states and the divider
// request and reply structs.
// ----------------------------------------------------------------------------
package rscrm_pkg;

    localparam int unsigned QW = 14;
    localparam int unsigned CW = 32;

    typedef enum logic [1:0] {
        t_REG_FIELD_SIZE = 2'd0,
        t_REG_MSG_LEN    = 2'd1,
        t_REG_CODE_LEN   = 2'd2,
        t_REG_GROUP_SIZE = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIG_START,
        S_DIG_WAIT,
        S_PT_START,
        S_HORNER,
        S_MOD_WAIT,
        S_OUT
    } t_state;

    // Request to the shared divider: dividend / divisor.
    typedef struct packed {
        logic          start;
        logic [CW-1:0] dividend;
        logic [QW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [CW-1:0] quotient;
        logic [QW-1:0] remainder;
    } t_div_rsp;

endpackage

/* sv/rscrm_div.sv */
// ----------------------------------------------------------------------------
// rscrm_div: shared restoring divider
// Divides a 32-bit value by a 14-bit modulus, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rscrm_div
    import rscrm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic          r_busy;
    logic [5:0]    r_cnt;
    logic [CW-1:0] r_quo;
    logic [QW:0]   r_rem;
    logic [QW-1:0] r_den;
    logic          r_done;

    logic [QW+1:0] w_shift;
    logic [QW+1:0] w_diff;

    assign w_shift = {r_rem, r_quo[CW-1]};
    assign w_diff  = w_shift - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(CW);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_diff[QW+1]) begin
                    r_rem <= w_diff[QW:0];
                    r_quo <= {r_quo[CW-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[QW:0];
                    r_quo <= {r_quo[CW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[QW-1:0];

endmodule

/* sv/reed_solomon_column_row_mapper_core.sv */
// ----------------------------------------------------------------------------
// reed_solomon_column_row_mapper_core: Kautz-Singleton column-to-row mapper
// Splits a column index into base-q digits and evaluates the Reed-Solomon
// polynomial at each point, emitting the symbol and matrix row per point.
// ----------------------------------------------------------------------------
// One item is handled at a time. All division and reduction runs through a
// single restoring divider that yields one quotient bit per cycle. A digit
// is one divider launch, the quotient bits and the taking of the reply. A
// Horner step first registers the product s*x in S_HORNER and then launches
// the divider on product plus digit. Each point also passes through a start
// state, forms its result and holds that result until it is taken. An
// out-of-range column yields a single error item. Input stall is high from
// acceptance until the last result of the item has been taken.
// Configuration writes are always ready and must be made while idle.
module reed_solomon_column_row_mapper_core
    import rscrm_pkg::*;
#(
    parameter int unsigned MAX_CODE_LENGTH = 64,
    parameter int unsigned MAX_DIGITS      = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_column_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_eval_point,
    output logic [13:0] o_code_symbol,
    output logic [19:0] o_row_index,
    output logic        o_index_error,
    output logic        o_last
);

    localparam int unsigned DW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Configuration registers.
    logic [13:0] r_field_size;
    logic [6:0]  r_msg_len;
    logic [6:0]  r_code_len;
    logic [31:0] r_group_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_size <= 14'd3;
            r_msg_len    <= 7'd1;
            r_code_len   <= 7'd3;
            r_group_size <= 32'd2;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                t_REG_FIELD_SIZE: r_field_size <= i_cfg_data[13:0];
                t_REG_MSG_LEN:    r_msg_len    <= i_cfg_data[6:0];
                t_REG_CODE_LEN:   r_code_len   <= i_cfg_data[6:0];
                t_REG_GROUP_SIZE: r_group_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective settings with the clamps applied.
    logic [13:0] w_q;
    logic [6:0]  w_ndig;
    logic [6:0]  w_npts;

    assign w_q    = (r_field_size < 14'd2) ? 14'd2 : r_field_size;
    assign w_ndig = (r_msg_len > 7'(MAX_DIGITS)) ? 7'(MAX_DIGITS) : r_msg_len;
    always_comb begin
        w_npts = (r_code_len == 7'd0) ? 7'd1 : r_code_len;
        if (w_npts > 7'(MAX_CODE_LENGTH)) begin
            w_npts = 7'(MAX_CODE_LENGTH);
        end
    end

    t_div_req div_req;
    t_div_rsp div_rsp;

    // Digit memory, written during extraction, read during Horner steps.
    logic [13:0] r_dig_mem [MAX_DIGITS];
    logic [13:0] r_dig_rd;
    logic        w_dig_we;
    logic [DW-1:0] w_dig_wa;
    logic [DW-1:0] w_dig_ra;

    always_ff @(posedge i_clk) begin
        if (w_dig_we) begin
            r_dig_mem[w_dig_wa] <= div_rsp.remainder;
        end
        r_dig_rd <= r_dig_mem[w_dig_ra];
    end

    rscrm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    t_state r_state, n_state;
    logic [31:0] r_rem, n_rem;
    logic [6:0]  r_i, n_i;        // digit counter
    logic [6:0]  r_p, n_p;        // point counter
    logic [13:0] r_x, n_x;        // p mod q
    logic [13:0] r_s, n_s;        // Horner accumulator
    logic [27:0] r_prod, n_prod;  // s*x registered before the add
    logic        r_err, n_err;
    logic        r_ovalid, n_ovalid;
    logic [5:0]  r_opt, n_opt;
    logic [13:0] r_osym, n_osym;
    logic [19:0] r_orow, n_orow;
    logic        r_olast, n_olast;

    // Launch marker: high in the first cycle of S_MOD_WAIT, when the product and
    // the digit read are both registered.
    logic r_launch;

    logic [19:0] w_pq;
    assign w_pq = 20'(r_p) * 20'(w_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_rem  <= n_rem;
        r_i    <= n_i;
        r_p    <= n_p;
        r_x    <= n_x;
        r_s    <= n_s;
        r_prod <= n_prod;
        r_err  <= n_err;
        r_opt  <= n_opt;
        r_osym <= n_osym;
        r_orow <= n_orow;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_i      = r_i;
        n_p      = r_p;
        n_x      = r_x;
        n_s      = r_s;
        n_prod   = r_prod;
        n_err    = r_err;
        n_ovalid = r_ovalid;
        n_opt    = r_opt;
        n_osym   = r_osym;
        n_orow   = r_orow;
        n_olast  = r_olast;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = w_q;
        w_dig_we = 1'b0;
        w_dig_wa = r_i[DW-1:0];
        w_dig_ra = DW'(r_i - 7'd1);
        o_stall  = 1'b1;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_rem = i_column_index;
                    n_i   = 7'd0;
                    n_p   = 7'd0;
                    n_x   = 14'd0;
                    if (i_column_index >= r_group_size) begin
                        n_err   = 1'b1;
                        n_opt   = '0;
                        n_osym  = '0;
                        n_orow  = '0;
                        n_olast = 1'b1;
                        n_ovalid = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_err   = 1'b0;
                        n_state = S_DIG_START;
                    end
                end
            end
            S_DIG_START: begin
                if (r_i == w_ndig) begin
                    n_state = S_PT_START;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_rem;
                    n_state = S_DIG_WAIT;
                end
            end
            S_DIG_WAIT: begin
                if (div_rsp.done) begin
                    w_dig_we = 1'b1;
                    n_rem = div_rsp.quotient;
                    n_i   = r_i + 7'd1;
                    n_state = S_DIG_START;
                end
            end
            S_PT_START: begin
                // r_i holds the digit count; digits are read top down.
                n_s    = 14'd0;
                n_prod = '0;
                n_state = S_HORNER;
            end
            S_HORNER: begin
                if (r_i == 7'd0) begin
                    if (!r_ovalid || !i_stall) begin
                        n_ovalid = 1'b1;
                        n_opt    = r_p[5:0];
                        n_osym   = r_s;
                        n_orow   = w_pq + 20'(r_s);
                        n_olast  = (r_p + 7'd1 == w_npts);
                        n_state  = S_OUT;
                    end
                end else begin
                    // The product is registered here while the digit is read;
                    // both are ready in the first cycle of S_MOD_WAIT.
                    n_prod = 28'(r_s) * 28'(r_x);
                    n_state = S_MOD_WAIT;
                end
            end
            S_MOD_WAIT: begin
                if (div_rsp.done) begin
                    n_s = div_rsp.remainder;
                    n_i = r_i - 7'd1;
                    n_state = S_HORNER;
                end
            end
            S_OUT: begin
                if (!n_ovalid) begin
                    if (r_err || r_olast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_p = r_p + 7'd1;
                        n_x = (r_x + 14'd1 == w_q) ? 14'd0 : r_x + 14'd1;
                        n_i = w_ndig;
                        n_state = S_PT_START;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Divider launch for a Horner step: reduce product plus digit.
        if (r_state == S_MOD_WAIT && r_launch) begin
            div_req.start    = 1'b1;
            div_req.dividend = 32'(r_prod) + 32'(r_dig_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= 1'b0;
        end else begin
            r_launch <= (r_state == S_HORNER) && (r_i != 7'd0);
        end
    end

    assign o_valid       = r_ovalid;
    assign o_eval_point  = r_opt;
    assign o_code_symbol = r_osym;
    assign o_row_index   = r_orow;
    assign o_index_error = r_err;
    assign o_last        = r_olast;

endmodule

/* sv/rscrm_checker.sv */
// ----------------------------------------------------------------------------
// rscrm_props: port-level checks of the column-to-row mapper
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module rscrm_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [13:0] o_code_symbol,
    input logic [19:0] o_row_index,
    input logic [5:0]  o_eval_point,
    input logic        o_index_error,
    input logic        o_last
);

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_error) |-> o_last)
        else $error("error item without last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_error) |->
            (o_row_index == 20'd0 && o_eval_point == 6'd0 && o_code_symbol == 14'd0))
        else $error("error item with nonzero fields");

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input ready while result pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_row_index)))
        else $error("stalled result changed");

endmodule

bind reed_solomon_column_row_mapper_core rscrm_props u_rscrm_props (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_code_symbol(o_code_symbol),
    .o_row_index  (o_row_index),
    .o_eval_point (o_eval_point),
    .o_index_error(o_index_error),
    .o_last       (o_last)
);

/* verif/rscrm_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rscrm_checker: row prediction and comparison for the column-to-row mapper
// Follows register writes and accepted columns, predicts the row items of
// each column and compares every accepted row item with the oldest one.
// ----------------------------------------------------------------------------
module rscrm_checker
    import rscrm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_stall,
    input  logic [31:0] i_column_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [5:0]  i_eval_point,
    input  logic [13:0] i_code_symbol,
    input  logic [19:0] i_row_index,
    input  logic        i_index_error,
    input  logic        i_last,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_rows_seen
);

    typedef struct packed {
        logic [5:0]  point;
        logic [13:0] symbol;
        logic [19:0] row;
        logic        err;
        logic        last;
    } t_row_item;

    logic [13:0] field_q;
    logic [6:0]  msg_len;
    logic [6:0]  code_len;
    logic [31:0] group_sz;
    t_row_item   row_q[$];

    function automatic void predict_rows(input logic [31:0] col);
        logic [63:0] q, rem, x, s, row;
        logic [63:0] digit[64];
        int          ndig, npts;
        t_row_item   it;
        q    = (field_q < 2) ? 64'd2 : 64'(field_q);
        ndig = (msg_len > 64) ? 64 : int'(msg_len);
        npts = (code_len == 0) ? 1 : ((code_len > 64) ? 64 : int'(code_len));
        if (col >= group_sz) begin
            it = '{point: '0, symbol: '0, row: '0, err: 1'b1, last: 1'b1};
            row_q.push_back(it);
        end else begin
            rem = 64'(col);
            for (int i = 0; i < ndig; i++) begin
                digit[i] = rem % q;
                rem      = rem / q;
            end
            for (int p = 0; p < npts; p++) begin
                x = 64'(p) % q;
                s = 0;
                for (int i = ndig - 1; i >= 0; i--) begin
                    s = (s * x + digit[i]) % q;
                end
                row = 64'(p) * q + s;
                it = '{point: p[5:0], symbol: s[13:0], row: row[19:0], err: 1'b0,
                       last: (p + 1 == npts)};
                row_q.push_back(it);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_row_item want;
        if (!i_rst_n) begin
            field_q      <= 14'd3;
            msg_len      <= 7'd1;
            code_len     <= 7'd3;
            group_sz     <= 32'd2;
            o_mismatches <= 0;
            o_rows_seen  <= 0;
            row_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    t_REG_FIELD_SIZE: field_q  <= i_cfg_data[13:0];
                    t_REG_MSG_LEN:    msg_len  <= i_cfg_data[6:0];
                    t_REG_CODE_LEN:   code_len <= i_cfg_data[6:0];
                    t_REG_GROUP_SIZE: group_sz <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall) predict_rows(i_column_index);
            if (i_out_valid && !i_out_stall) begin
                o_rows_seen <= o_rows_seen + 1;
                if (row_q.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("[%0t] unexpected row item: point %0d row %0d",
                                 $time, i_eval_point, i_row_index);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = row_q.pop_front();
                    if (want.point !== i_eval_point || want.symbol !== i_code_symbol ||
                        want.row !== i_row_index || want.err !== i_index_error ||
                        want.last !== i_last) begin
                        if (o_mismatches < 10) begin
                            $display("[%0t] row item differs: exp pt %0d sym %0d row %0d err %0b last %0b",
                                     $time, want.point, want.symbol, want.row,
                                     want.err, want.last);
                            $display("[%0t]                   got pt %0d sym %0d row %0d err %0b last %0b",
                                     $time, i_eval_point, i_code_symbol, i_row_index,
                                     i_index_error, i_last);
                        end
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
        end
        o_pending = row_q.size();
    end

endmodule

/* verif/reed_solomon_column_row_mapper_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reed_solomon_column_row_mapper_core_tb: testbench of the column mapper
// Drives register settings and column items through the mapper, with random
// sender gaps and receiver stalls, while a checker predicts every row item.
// ----------------------------------------------------------------------------
module reed_solomon_column_row_mapper_core_tb;
    import rscrm_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_column_index;
    logic        o_valid;
    logic        i_stall;
    logic [5:0]  o_eval_point;
    logic [13:0] o_code_symbol;
    logic [19:0] o_row_index;
    logic        o_index_error;
    logic        o_last;

    int mismatches;
    int pending;
    int rows_seen;
    int columns_sent;
    int phases_run;

    // Idling percentages, changed from phase to phase.
    int gap_pct;
    int stall_pct;

    // Current group size, kept so that columns can be aimed in range.
    logic [31:0] cur_group;

    reed_solomon_column_row_mapper_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_column_index (i_column_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_eval_point   (o_eval_point),
        .o_code_symbol  (o_code_symbol),
        .o_row_index    (o_row_index),
        .o_index_error  (o_index_error),
        .o_last         (o_last)
    );

    rscrm_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_stall        (o_stall),
        .i_column_index (i_column_index),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_eval_point   (o_eval_point),
        .i_code_symbol  (o_code_symbol),
        .i_row_index    (o_row_index),
        .i_index_error  (o_index_error),
        .i_last         (o_last),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_rows_seen    (rows_seen)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // The receiver stalls at random; the chance is set per phase.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Writes one register and holds valid until the block takes it.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Loads all four registers; the block must be idle when this is called.
    task automatic load_setting(input logic [13:0] q, input logic [6:0] m,
                                input logic [6:0] n, input logic [31:0] grp);
        write_reg(t_REG_FIELD_SIZE, 32'(q));
        write_reg(t_REG_MSG_LEN, 32'(m));
        write_reg(t_REG_CODE_LEN, 32'(n));
        write_reg(t_REG_GROUP_SIZE, grp);
        cur_group = grp;
    endtask

    // Offers one column item after a random gap. Valid stays high and the
    // payload stays put until an edge sees valid high and stall low. Valid
    // is dropped by the next gap or by drain, so back-to-back items keep it
    // high.
    task automatic send_column(input logic [31:0] col);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_column_index <= col;
        do @(posedge i_clk); while (o_stall);
        columns_sent++;
        @(negedge i_clk);
    endtask

    // Waits until every predicted row item has come back, then lets the
    // block settle so that a new setting can be written.
    task automatic drain;
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Picks a column: mostly inside the group, sometimes anywhere.
    function automatic logic [31:0] pick_column;
        if (cur_group != 0 && $urandom_range(9) < 8)
            return $urandom % cur_group;
        return $urandom;
    endfunction

    function automatic logic [13:0] pick_field;
        int sel;
        sel = $urandom_range(11);
        case (sel)
            0: return 14'd0;
            1: return 14'd1;
            2: return 14'd2;
            3: return 14'd3;
            4: return 14'd5;
            5: return 14'd7;
            6: return 14'd251;
            7: return 14'd9973;
            8: return 14'd16383;
            9: return 14'd12;
            default: return 14'($urandom_range(2, 16383));
        endcase
    endfunction

    initial begin
        int ncols;
        logic [6:0] m, n;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_column_index = '0;
        i_stall        = 1'b0;
        gap_pct        = 0;
        stall_pct      = 0;
        columns_sent   = 0;
        phases_run     = 0;
        cur_group      = 32'd2;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part. Reset setting first: columns in range and beyond.
        send_column(32'd0);
        send_column(32'd1);
        send_column(32'd2);
        send_column(32'hFFFF_FFFF);
        drain();
        // Zero group size flags every column.
        load_setting(14'd7, 7'd3, 7'd5, 32'd0);
        send_column(32'd0);
        send_column(32'h5555_AAAA);
        drain();
        // Field size below two, zero message length, zero code length.
        load_setting(14'd0, 7'd0, 7'd0, 32'hFFFF_FFFF);
        send_column(32'hAAAA_5555);
        drain();
        load_setting(14'd1, 7'd2, 7'd4, 32'hFFFF_FFFF);
        send_column(32'd3);
        send_column(32'hFFFF_FFFE);
        drain();
        // Code length past the field size, and a composite modulus.
        load_setting(14'd3, 7'd2, 7'd10, 32'hFFFF_FFFF);
        send_column(32'd7);
        drain();
        load_setting(14'd16383, 7'd3, 7'd64, 32'hFFFF_FFFF);
        send_column(32'hFFFF_FFFE);
        drain();
        // A large prime with saturated lengths; this one column is slow.
        load_setting(14'd9973, 7'd127, 7'd127, 32'hFFFF_FFFF);
        send_column(32'hDEAD_BEEF);
        drain();
        load_setting(14'd9973, 7'd64, 7'd1, 32'hFFFF_FFFF);
        send_column(32'hFFFF_FFFE);
        send_column(32'd9972);
        drain();
        load_setting(14'd2, 7'd64, 7'd2, 32'h8000_0000);
        send_column(32'h7FFF_FFFF);
        send_column(32'h8000_0000);
        drain();

        // Random phases: each picks a setting and an idling mode.
        while (columns_sent < 280) begin
            case (phases_run % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 71; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 71; end
                default: begin gap_pct = 20; stall_pct = 20; end
            endcase
            // Mostly short codes keep the run fast; now and then one
            // length goes out to its saturating range.
            m = 7'($urandom_range(0, 4));
            n = 7'($urandom_range(0, 8));
            if ($urandom_range(9) == 0) m = 7'($urandom_range(60, 127));
            else if ($urandom_range(9) == 0) n = 7'($urandom_range(60, 127));
            case ($urandom_range(4))
                0: load_setting(pick_field(), m, n, 32'hFFFF_FFFF);
                1: load_setting(pick_field(), m, n, 32'($urandom_range(1, 50)));
                2: load_setting(pick_field(), m, n, 32'd0);
                default: load_setting(pick_field(), m, n, $urandom);
            endcase
            ncols = $urandom_range(6, 14);
            repeat (ncols) send_column(pick_column());
            drain();
            phases_run++;
        end

        repeat (100) @(negedge i_clk);
        $display("Sent %0d columns over %0d random phases and checked %0d row items.",
                 columns_sent, phases_run, rows_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #200ms;
        $display("Run timed out with %0d row items outstanding.", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
